// ===== design/csll_pkg.sv =====
// shared types, constants and lookup tables of the codon log-likelihood core
// no dependencies
`default_nettype none
package csll_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SCORE,
      ST_EXP1,
      ST_EXP2,
      ST_ACC,
      ST_LN1,
      ST_LN2,
      ST_LN3,
      ST_CLOSE,
      ST_OUT
   } state_type;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_COUNT = 1'b1;

   localparam int unsigned VAL_W = 24;
   localparam int unsigned LIK_W = 48;
   localparam int unsigned WORD_W = 2 * VAL_W;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [15:0] LN2_Q16 = 16'd45426;
   localparam logic [3:0]  EXP_INT_LIMIT = 4'd12;

   localparam logic [16:0] EXP_INT_TAB [12] = '{
      17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
      17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1
   };

   localparam logic [16:0] EXP_FRAC_TAB [17] = '{
      17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51040, 17'd47947,
      17'd45042, 17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954,
      17'd30957, 17'd29081, 17'd27319, 17'd25664, 17'd24109
   };

   localparam logic [15:0] LN_TAB [17] = '{
      16'd0, 16'd3973, 16'd7719, 16'd11262, 16'd14624, 16'd17821,
      16'd20870, 16'd23783, 16'd26573, 16'd29248, 16'd31818, 16'd34292,
      16'd36675, 16'd38975, 16'd41196, 16'd43352, 16'd45426
   };

endpackage
`default_nettype wire

// ===== design/codon_softmax_log_likelihood_core.sv =====
// top level of the codon log-likelihood core: sequencer, score, exp/ln and accumulators
// depends on csll_pkg and csll_param_mem
//
// A load transaction (req_action = 0) writes the bias and selection values of one
// table entry; indexes at or above PARAM_ENTRIES are dropped. A count transaction
// (req_action = 1) walks one codon through table read, score multiply, two-step exp
// lookup and the online log-sum-exp update before the next request is accepted. A
// reference codon closes its amino-acid group through a leading-one normalise, ln
// lookup and count*logZ multiply. A gene-end codon then places the gene sum in the
// output register, and waits there only while a previous result is still untaken.
// The single shared datapath handles one codon at a time because each update
// depends on the group state left by the codon before. The table memory has no
// clear: an entry read before it was written gives unknown data.
`default_nettype none
module codon_softmax_log_likelihood_core #(
   parameter int unsigned PARAM_ENTRIES = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire                 req_action,
   input  wire  [5:0]          req_param_index,
   input  wire  signed [23:0]  req_mutation_bias,
   input  wire  signed [23:0]  req_selection_coef,
   input  wire  [23:0]         req_expression_level,
   input  wire  [15:0]         req_codon_count,
   input  wire                 req_is_reference,
   input  wire                 req_gene_end,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic signed [47:0]  rsp_gene_log_lik,
   output logic                rsp_saturated
);
   import csll_pkg::*;

   localparam int unsigned AW = (PARAM_ENTRIES > 1) ? $clog2(PARAM_ENTRIES) : 1;

   // handshake and table access
   logic              req_fire;
   logic              in_range;
   logic [AW-1:0]     tab_addr;
   logic [WORD_W-1:0] rd_data;
   logic signed [23:0] tab_bias;
   logic signed [23:0] tab_sel;

   state_type state_ff, state_in;

   // latched codon transaction
   logic [15:0] cnt_ff, cnt_in;
   logic [23:0] phi_ff, phi_in;
   logic        ref_ff, ref_in;
   logic        end_ff, end_in;
   logic        hit_ff, hit_in;

   // score and exp pipeline
   logic signed [48:0] prod_ff, prod_in;
   logic signed [23:0] score_ff, score_in;
   logic               gt_ff, gt_in;
   logic [16:0]        fv_ff, fv_in;
   logic [3:0]         ei_ff, ei_in;
   logic               big_ff, big_in;
   logic signed [40:0] wprod_ff, wprod_in;
   logic [16:0]        e_ff, e_in;

   // group and gene state
   logic signed [23:0] gmax_ff, gmax_in;
   logic [31:0]        gsum_ff, gsum_in;
   logic signed [47:0] gwt_ff, gwt_in;
   logic [31:0]        gtot_ff, gtot_in;
   logic               gopen_ff, gopen_in;
   logic signed [47:0] gene_ff, gene_in;
   logic               clip_ff, clip_in;

   // ln and close path
   logic [3:0]         sh_ff, sh_in;
   logic [3:0]         lk_ff, lk_in;
   logic [11:0]        lr_ff, lr_in;
   logic               low_ff, low_in;
   logic signed [25:0] logz_ff, logz_in;
   logic signed [58:0] zprod_ff, zprod_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_lik_ff, rsp_lik_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // combinational working values
   logic signed [34:0] score_w;
   logic signed [24:0] diff_w;
   logic [23:0]        dabs_w;
   logic [4:0]         fk_w;
   logic [16:0]        fa_w, fb_w;
   logic [24:0]        fint_w;
   logic [33:0]        eprod_w;
   logic [48:0]        rprod_w;
   logic [33:0]        radd_w;
   logic [32:0]        sadd_w;
   logic signed [48:0] wsum_w;
   logic [32:0]        tsum_w;
   logic [4:0]         lead_w;
   logic [31:0]        norm_w;
   logic [19:0]        lsh_w;
   logic [15:0]        ldel_w;
   logic [24:0]        lint_w;
   logic [20:0]        ln_w;
   logic signed [60:0] gacc_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = 32'(req_param_index) < PARAM_ENTRIES;
   assign tab_addr  = AW'(req_param_index);
   assign tab_bias  = $signed(rd_data[WORD_W-1:VAL_W]);
   assign tab_sel   = $signed(rd_data[VAL_W-1:0]);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gene_log_lik = rsp_lik_ff;
   assign rsp_saturated    = rsp_sat_ff;

   csll_param_mem #(
      .WORDS (PARAM_ENTRIES),
      .AW    (AW)
   ) u_param_mem (
      .clock   (clock),
      .wr_en   (req_fire && (req_action == ACT_LOAD) && in_range),
      .wr_addr (tab_addr),
      .wr_data ({req_mutation_bias, req_selection_coef}),
      .rd_en   (req_fire && (req_action == ACT_COUNT)),
      .rd_addr (tab_addr),
      .rd_data (rd_data)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, datapath next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phi_in       = phi_ff;
      ref_in       = ref_ff;
      end_in       = end_ff;
      hit_in       = hit_ff;
      prod_in      = prod_ff;
      score_in     = score_ff;
      gt_in        = gt_ff;
      fv_in        = fv_ff;
      ei_in        = ei_ff;
      big_in       = big_ff;
      wprod_in     = wprod_ff;
      e_in         = e_ff;
      gmax_in      = gmax_ff;
      gsum_in      = gsum_ff;
      gwt_in       = gwt_ff;
      gtot_in      = gtot_ff;
      gopen_in     = gopen_ff;
      gene_in      = gene_ff;
      clip_in      = clip_ff;
      sh_in        = sh_ff;
      lk_in        = lk_ff;
      lr_in        = lr_ff;
      low_in       = low_ff;
      logz_in      = logz_ff;
      zprod_in     = zprod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_lik_in   = rsp_lik_ff;
      rsp_sat_in   = rsp_sat_ff;

      // score: -bias - floor(sel*phi / 2^16), clipped to q8.16
      score_w = -35'(tab_bias) - 35'($signed(prod_ff[48:16]));

      // exp(-|score - max|): fraction part by interpolation
      diff_w = 25'(score_ff) - 25'(gmax_ff);
      dabs_w = (diff_w > 25'sd0) ? 24'(diff_w) : 24'(-diff_w);
      fk_w   = {1'b0, dabs_w[15:12]};
      fa_w   = EXP_FRAC_TAB[fk_w];
      fb_w   = EXP_FRAC_TAB[fk_w + 5'd1];
      fint_w = 25'(fa_w - fb_w) * 25'(dabs_w[11:0]) + 25'd2048;
      eprod_w = 34'(EXP_INT_TAB[ei_ff]) * 34'(fv_ff) + 34'd32768;

      // group accumulator updates
      rprod_w = 49'(gsum_ff) * 49'(e_ff) + 49'd32768;
      radd_w  = 34'(rprod_w[48:16]) + 34'(ONE_Q16);
      sadd_w  = 33'(gsum_ff) + 33'(e_ff);
      wsum_w  = 49'(gwt_ff) + 49'(wprod_ff);
      tsum_w  = 33'(gtot_ff) + 33'(cnt_ff);

      // ln: leading one of the sum, then table and interpolation
      lead_w = 5'd16;
      for (int p = 16; p < 32; p++) begin
         if (gsum_ff[p]) begin
            lead_w = 5'(p);
         end
      end
      norm_w = gsum_ff >> (lead_w - 5'd16);
      lsh_w  = 20'(sh_ff) * 20'(LN2_Q16);
      ldel_w = LN_TAB[{1'b0, lk_ff} + 5'd1] - LN_TAB[{1'b0, lk_ff}];
      lint_w = 25'(ldel_w) * 25'(lr_ff) + 25'd2048;
      ln_w   = low_ff ? 21'd0
             : 21'(lsh_w) + 21'(LN_TAB[{1'b0, lk_ff}]) + 21'(lint_w[24:12]);

      gacc_w = 61'(gene_ff) + 61'(gwt_ff) - 61'(zprod_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_COUNT)) begin
               cnt_in   = req_codon_count;
               phi_in   = req_expression_level;
               ref_in   = req_is_reference;
               end_in   = req_gene_end;
               hit_in   = in_range && !req_is_reference;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            prod_in  = tab_sel * $signed({1'b0, phi_ff});
            state_in = ST_SCORE;
         end
         ST_SCORE: begin
            if (!hit_ff) begin
               score_in = '0;
            end else if (score_w > 35'sd8388607) begin
               score_in = 24'sh7FFFFF;
            end else if (score_w < -35'sd8388608) begin
               score_in = -24'sh800000;
            end else begin
               score_in = 24'(score_w);
            end
            state_in = ST_EXP1;
         end
         ST_EXP1: begin
            gt_in    = diff_w > 25'sd0;
            big_in   = dabs_w[23:16] >= 8'(EXP_INT_LIMIT);
            ei_in    = dabs_w[19:16];
            fv_in    = fa_w - 17'(fint_w[24:12]);
            wprod_in = $signed({1'b0, cnt_ff}) * score_ff;
            state_in = ST_EXP2;
         end
         ST_EXP2: begin
            e_in = big_ff ? 17'd0 : 17'(eprod_w[33:16]);
            if (wsum_w > 49'sh0_7FFF_FFFF_FFFF) begin
               gwt_in = 48'sh7FFF_FFFF_FFFF;
            end else if (wsum_w < -49'sh0_8000_0000_0000) begin
               gwt_in = -48'sh8000_0000_0000;
            end else begin
               gwt_in = 48'(wsum_w);
            end
            gtot_in  = tsum_w[32] ? 32'hFFFF_FFFF : tsum_w[31:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!gopen_ff) begin
               gmax_in  = score_ff;
               gsum_in  = 32'(ONE_Q16);
               gopen_in = 1'b1;
            end else if (gt_ff) begin
               gsum_in = (radd_w[33:32] != 2'd0) ? 32'hFFFF_FFFF : radd_w[31:0];
               gmax_in = score_ff;
            end else begin
               gsum_in = sadd_w[32] ? 32'hFFFF_FFFF : sadd_w[31:0];
            end
            if (ref_ff) begin
               state_in = ST_LN1;
            end else if (end_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LN1: begin
            low_in   = gsum_ff < 32'(ONE_Q16);
            sh_in    = 4'(lead_w - 5'd16);
            lk_in    = norm_w[15:12];
            lr_in    = norm_w[11:0];
            state_in = ST_LN2;
         end
         ST_LN2: begin
            logz_in  = 26'(gmax_ff) + $signed({5'd0, ln_w});
            state_in = ST_LN3;
         end
         ST_LN3: begin
            zprod_in = $signed({1'b0, gtot_ff}) * logz_ff;
            state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            if (gacc_w > 61'sh0_7FFF_FFFF_FFFF) begin
               gene_in = 48'sh7FFF_FFFF_FFFF;
               clip_in = 1'b1;
            end else if (gacc_w < -61'sh0_8000_0000_0000) begin
               gene_in = -48'sh8000_0000_0000;
               clip_in = 1'b1;
            end else begin
               gene_in = 48'(gacc_w);
            end
            gmax_in  = '0;
            gsum_in  = '0;
            gwt_in   = '0;
            gtot_in  = '0;
            gopen_in = 1'b0;
            state_in = end_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            // an untaken earlier result holds the gene here
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_lik_in   = gene_ff;
               rsp_sat_in   = clip_ff;
               gmax_in      = '0;
               gsum_in      = '0;
               gwt_in       = '0;
               gtot_in      = '0;
               gopen_in     = 1'b0;
               gene_in      = '0;
               clip_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // group, gene and output control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gmax_ff      <= '0;
         gsum_ff      <= '0;
         gwt_ff       <= '0;
         gtot_ff      <= '0;
         gopen_ff     <= 1'b0;
         gene_ff      <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gmax_ff      <= gmax_in;
         gsum_ff      <= gsum_in;
         gwt_ff       <= gwt_in;
         gtot_ff      <= gtot_in;
         gopen_ff     <= gopen_in;
         gene_ff      <= gene_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      phi_ff     <= phi_in;
      ref_ff     <= ref_in;
      end_ff     <= end_in;
      hit_ff     <= hit_in;
      prod_ff    <= prod_in;
      score_ff   <= score_in;
      gt_ff      <= gt_in;
      fv_ff      <= fv_in;
      ei_ff      <= ei_in;
      big_ff     <= big_in;
      wprod_ff   <= wprod_in;
      e_ff       <= e_in;
      sh_ff      <= sh_in;
      lk_ff      <= lk_in;
      lr_ff      <= lr_in;
      low_ff     <= low_in;
      logz_ff    <= logz_in;
      zprod_ff   <= zprod_in;
      rsp_lik_ff <= rsp_lik_in;
      rsp_sat_ff <= rsp_sat_in;
   end

endmodule
`default_nettype wire

// ===== design/csll_param_mem.sv =====
// parameter table memory: bias and selection per entry, one write and one read port
// registered read data, depends on csll_pkg
`default_nettype none
module csll_param_mem #(
   parameter int unsigned WORDS = 64,
   parameter int unsigned AW = 6
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [AW-1:0]                wr_addr,
   input  wire  [csll_pkg::WORD_W-1:0]  wr_data,
   input  wire                          rd_en,
   input  wire  [AW-1:0]                rd_addr,
   output logic [csll_pkg::WORD_W-1:0]  rd_data
);
   import csll_pkg::*;

   logic [WORD_W-1:0] mem_ff [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire
